[rtl/ultrasonic_tank_level_median_unit_defines.svh]
// ----------------------------------------------------------------------------
// ultrasonic tank level median unit - assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_TANK_LEVEL_MEDIAN_UNIT_DEFINES_SVH
`define ULTRASONIC_TANK_LEVEL_MEDIAN_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define UTLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UTLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/utlm_pkg.sv]
// ----------------------------------------------------------------------------
// utlm_pkg
// Types and constants shared by the tank level median unit.
// ----------------------------------------------------------------------------
package utlm_pkg;

    // defaults for the top-level parameters
    localparam int SAMPLE_COUNT_DEF = 5;
    localparam int MAX_RANGE_CM_DEF = 400;

    // field widths
    localparam int ECHO_W     = 15;
    localparam int LEVEL_W    = 13;
    localparam int PCT_W      = 14;
    localparam int VOL_W      = 32;
    localparam int DIM_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 64;

    // echo to distance: (echo*16 + 29) / 58 via reciprocal multiply
    localparam int                ECHO_NUM_W = 19;
    localparam logic [ECHO_W-1:0] ECHO_LIMIT = 15'd23780;
    localparam logic [5:0]        US_PER_CM  = 6'd58;
    localparam logic [4:0]        HALF_US_CM = 5'd29;
    localparam int                RECIP_W    = 20;
    localparam logic [RECIP_W-1:0] RECIP_M   = 20'd578525;
    localparam int                RECIP_S    = 25;

    // percentage and volume
    localparam logic [PCT_W-1:0] PCT_FULL  = 14'd10000;
    localparam int               PCT_NUM_W = 27;
    localparam int               PI_W      = 30;
    localparam logic [PI_W-1:0]  PI_Q28    = 30'd843314857;

    // register reset values
    localparam logic [LEVEL_W-1:0] EMPTY_RST = 13'd3200;
    localparam logic [LEVEL_W-1:0] FULL_RST  = 13'd320;
    localparam logic [DIM_W-1:0]   DIM_RST   = 10'd100;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMPTY  = 3'd0,
        REG_FULL   = 3'd1,
        REG_ROUND  = 3'd2,
        REG_LENGTH = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_DIAM   = 3'd5
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_START,
        ST_CALC,
        ST_OUT
    } state_t;

    // what one sort cell hands to its right neighbor
    typedef struct packed {
        logic [LEVEL_W-1:0] value;
        logic               take;
    } cell_link_t;

    localparam cell_link_t LINK_NONE = '{value: '0, take: 1'b0};

endpackage

[rtl/ultrasonic_tank_level_median_unit.sv]
// A sample passes through the converter and is then inserted into the sort row; the
// input is not taken again until the insert, so one sample is handled at a time.
// The closing sample's result then goes through prep, start, 27 bit-serial divider
// steps and the output load, which waits while the output is stalled; the input
// reopens in the same cycle that the result becomes valid, so groups do not overlap.
// Reset (aresetn low, synchronous) clears sequencer, count, output valid; loads tank defaults.
// ----------------------------------------------------------------------------
// ultrasonic_tank_level_median_unit
// Median of a group of echo samples, then level, fill percent and volume.
// ----------------------------------------------------------------------------
`include "ultrasonic_tank_level_median_unit_defines.svh"

module ultrasonic_tank_level_median_unit #(
    parameter int SAMPLE_COUNT = utlm_pkg::SAMPLE_COUNT_DEF,
    parameter int MAX_RANGE_CM = utlm_pkg::MAX_RANGE_CM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // echo_us [14:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [utlm_pkg::S_TDATA_W-1:0]  s_tdata,
    // level_q4 [12:0], percent_centi [26:13], volume_ml [58:27]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [utlm_pkg::M_TDATA_W-1:0]  m_tdata,
    // register write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [utlm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [utlm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(SAMPLE_COUNT);
    localparam int MED   = SAMPLE_COUNT / 2;
    localparam int LW    = utlm_pkg::LEVEL_W;
    localparam int DW    = utlm_pkg::DIM_W;
    localparam int NW    = utlm_pkg::PCT_NUM_W;

    // configuration registers
    logic [LW-1:0] empty_reg;
    logic [LW-1:0] full_reg;
    logic          round_reg;
    logic [DW-1:0] length_reg;
    logic [DW-1:0] width_reg;
    logic [DW-1:0] diam_reg;

    utlm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;

    logic conv_start;
    logic conv_valid;
    logic [LW-1:0] conv_q4;
    logic insert;
    logic calc_start;
    logic out_load;
    logic out_free;

    utlm_pkg::cell_link_t link_out [SAMPLE_COUNT];
    logic [LW-1:0] median;

    logic [LW-1:0] lvl_reg;
    logic [NW-1:0] num_reg;
    logic [LW-1:0] den_reg;
    logic [LW-1:0] h_reg;
    logic          pct_zero_reg;
    logic          pct_full_reg;

    logic [LW-1:0] e_minus_l;
    logic [LW-1:0] e_minus_f;
    logic [LW-1:0] h_raw;
    logic [LW-1:0] h_max;

    logic          div_done;
    logic [NW-1:0] div_quot;
    logic          vol_done;
    logic [utlm_pkg::VOL_W-1:0] vol_ml;

    logic [utlm_pkg::PCT_W-1:0] pct_sel;
    logic                       m_tvalid_reg;
    logic [utlm_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // register writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_reg  <= utlm_pkg::EMPTY_RST;
            full_reg   <= utlm_pkg::FULL_RST;
            round_reg  <= 1'b0;
            length_reg <= utlm_pkg::DIM_RST;
            width_reg  <= utlm_pkg::DIM_RST;
            diam_reg   <= utlm_pkg::DIM_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                utlm_pkg::REG_EMPTY:  empty_reg  <= cfg_data;
                utlm_pkg::REG_FULL:   full_reg   <= cfg_data;
                utlm_pkg::REG_ROUND:  round_reg  <= cfg_data[0];
                utlm_pkg::REG_LENGTH: length_reg <= cfg_data[DW-1:0];
                utlm_pkg::REG_WIDTH:  width_reg  <= cfg_data[DW-1:0];
                utlm_pkg::REG_DIAM:   diam_reg   <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= utlm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            utlm_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = utlm_pkg::ST_CONV;
            end
            utlm_pkg::ST_CONV: begin
                if (conv_valid) begin
                    state_next = (cnt_reg == CNT_W'(SAMPLE_COUNT - 1)) ?
                                 utlm_pkg::ST_PREP : utlm_pkg::ST_IDLE;
                end
            end
            utlm_pkg::ST_PREP:  state_next = utlm_pkg::ST_START;
            utlm_pkg::ST_START: state_next = utlm_pkg::ST_CALC;
            utlm_pkg::ST_CALC: begin
                if (div_done) state_next = utlm_pkg::ST_OUT;
            end
            utlm_pkg::ST_OUT: begin
                if (out_free) state_next = utlm_pkg::ST_IDLE;
            end
            default: state_next = utlm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        insert     = 1'b0;
        calc_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            utlm_pkg::ST_IDLE:  s_tready   = 1'b1;
            utlm_pkg::ST_CONV:  insert     = conv_valid;
            utlm_pkg::ST_START: calc_start = 1'b1;
            utlm_pkg::ST_OUT:   out_load   = out_free;
            default: ;
        endcase
    end

    assign conv_start = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    // group fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (insert) begin
            cnt_reg <= (cnt_reg == CNT_W'(SAMPLE_COUNT - 1)) ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    // echo width to distance
    utlm_echo_conv #(
        .MAX_RANGE_CM (MAX_RANGE_CM)
    ) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (conv_start),
        .echo_us   (s_tdata[utlm_pkg::ECHO_W-1:0]),
        .out_valid (conv_valid),
        .dist_q4   (conv_q4)
    );

    // insertion sort row
    for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
        utlm_pkg::cell_link_t left;
        if (i == 0) begin : g_head
            assign left = utlm_pkg::LINK_NONE;
        end else begin : g_body
            assign left = link_out[i-1];
        end
        utlm_sort_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .insert   (insert),
            .count    (cnt_reg),
            .din      (conv_q4),
            .link_in  (left),
            .link_out (link_out[i])
        );
    end

    assign median = link_out[MED].value;

    // result setup from the median
    always_comb begin
        e_minus_l = empty_reg - median;
        e_minus_f = empty_reg - full_reg;
        h_raw     = (empty_reg > median) ? e_minus_l : '0;
        h_max     = (empty_reg > full_reg) ? e_minus_f : '0;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == utlm_pkg::ST_PREP) begin
            lvl_reg      <= median;
            num_reg      <= NW'(e_minus_l) * NW'(utlm_pkg::PCT_FULL) + NW'(e_minus_f >> 1);
            den_reg      <= e_minus_f;
            h_reg        <= (h_raw > h_max) ? h_max : h_raw;
            pct_zero_reg <= (median >= empty_reg);
            pct_full_reg <= (median <= full_reg);
        end
    end

    // percent division
    utlm_divider #(
        .NUM_W (NW),
        .DEN_W (LW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (calc_start),
        .numer   (num_reg),
        .denom   (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // volume
    utlm_volume u_vol (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (calc_start),
        .round_tank (round_reg),
        .dim_a      (round_reg ? diam_reg : length_reg),
        .dim_b      (round_reg ? diam_reg : width_reg),
        .height_q4  (h_reg),
        .done       (vol_done),
        .volume_ml  (vol_ml)
    );

    // percent selection, empty check first
    always_comb begin
        if (pct_zero_reg) begin
            pct_sel = '0;
        end else if (pct_full_reg) begin
            pct_sel = utlm_pkg::PCT_FULL;
        end else begin
            pct_sel = div_quot[utlm_pkg::PCT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {5'b00000, vol_ml, pct_sel, lvl_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `UTLM_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(SAMPLE_COUNT - 1), "group count out of range")
    `UTLM_ASSERT_NOW(a_div_in_calc, aclk, aresetn, div_done, state_reg == utlm_pkg::ST_CALC, "divider finished outside calc")
    `UTLM_ASSERT_NOW(a_vol_before_div, aclk, aresetn, vol_done, state_reg == utlm_pkg::ST_CALC, "volume finished outside calc")
    `UTLM_ASSERT_NOW(a_load_group_end, aclk, aresetn, out_load, cnt_reg == '0, "result loaded mid group")
    `UTLM_ASSERT_NOW(a_pct_bound, aclk, aresetn, m_tvalid, m_tdata[26:13] <= utlm_pkg::PCT_FULL, "percent above full scale")

endmodule

[rtl/utlm_echo_conv.sv]
// ----------------------------------------------------------------------------
// utlm_echo_conv
// Two-stage conversion of an echo width in us to a distance in cm Q4.
// ----------------------------------------------------------------------------
module utlm_echo_conv #(
    parameter int MAX_RANGE_CM = utlm_pkg::MAX_RANGE_CM_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic [utlm_pkg::ECHO_W-1:0]  echo_us,
    output logic                         out_valid,
    output logic [utlm_pkg::LEVEL_W-1:0] dist_q4
);

    localparam int NUM_W  = utlm_pkg::ECHO_NUM_W;
    localparam int PROD_W = NUM_W + utlm_pkg::RECIP_W;
    localparam int Q_W    = PROD_W - utlm_pkg::RECIP_S;
    localparam logic [utlm_pkg::LEVEL_W-1:0] NO_ECHO_Q4 =
        utlm_pkg::LEVEL_W'(MAX_RANGE_CM * 16);

    logic [utlm_pkg::ECHO_W-1:0] echo_clamp;
    logic [NUM_W-1:0]            num;
    logic [NUM_W-1:0]            num_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic                        no_echo_reg;
    logic                        v1_reg;
    logic                        v2_reg;
    logic [Q_W-1:0]              q_est;
    logic [NUM_W:0]              q_back;
    logic [Q_W-1:0]              q_fix;
    logic [utlm_pkg::LEVEL_W-1:0] dist_reg;

    // stage 1: clamp, round offset, reciprocal multiply
    always_comb begin
        echo_clamp = (echo_us > utlm_pkg::ECHO_LIMIT) ? utlm_pkg::ECHO_LIMIT : echo_us;
        num        = {echo_clamp, 4'b0000} + NUM_W'(utlm_pkg::HALF_US_CM);
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            num_reg     <= num;
            prod_reg    <= PROD_W'(num) * PROD_W'(utlm_pkg::RECIP_M);
            no_echo_reg <= (echo_us == '0);
        end
    end

    // stage 2: estimate is exact or one high, fix by back-multiply
    always_comb begin
        q_est  = prod_reg[PROD_W-1:utlm_pkg::RECIP_S];
        q_back = (NUM_W+1)'(q_est) * (NUM_W+1)'(utlm_pkg::US_PER_CM);
        q_fix  = (q_back > (NUM_W+1)'(num_reg)) ? q_est - Q_W'(1) : q_est;
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            dist_reg <= no_echo_reg ? NO_ECHO_Q4 : q_fix[utlm_pkg::LEVEL_W-1:0];
        end
    end

    // valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign dist_q4   = dist_reg;

endmodule

[rtl/utlm_sort_cell.sv]
// ----------------------------------------------------------------------------
// utlm_sort_cell
// One cell of the insertion sort row; keeps the row ascending.
// ----------------------------------------------------------------------------
module utlm_sort_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 3
) (
    input  logic                         aclk,
    input  logic                         insert,
    input  logic [CNT_W-1:0]             count,
    input  logic [utlm_pkg::LEVEL_W-1:0] din,
    input  utlm_pkg::cell_link_t         link_in,
    output utlm_pkg::cell_link_t         link_out
);

    logic [utlm_pkg::LEVEL_W-1:0] value_reg;
    logic                         empty;
    logic                         take;

    // cells at or past the fill count hold nothing of this group
    always_comb begin
        empty = (count <= CNT_W'(INDEX));
        take  = empty || (din < value_reg);
    end

    // on insert: take the left value if it moves down, else the new one
    always_ff @(posedge aclk) begin
        if (insert && take) begin
            value_reg <= link_in.take ? link_in.value : din;
        end
    end

    assign link_out = '{value: value_reg, take: take};

endmodule

[rtl/utlm_divider.sv]
// ----------------------------------------------------------------------------
// utlm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module utlm_divider #(
    parameter int NUM_W = utlm_pkg::PCT_NUM_W,
    parameter int DEN_W = utlm_pkg::LEVEL_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= denom;
            rem_reg <= '0;
            quo_reg <= numer;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

[rtl/utlm_volume.sv]
// ----------------------------------------------------------------------------
// utlm_volume
// Five-stage volume pipeline for rectangular or cylindrical tanks.
// ----------------------------------------------------------------------------
module utlm_volume (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         round_tank,
    input  logic [utlm_pkg::DIM_W-1:0]   dim_a,
    input  logic [utlm_pkg::DIM_W-1:0]   dim_b,
    input  logic [utlm_pkg::LEVEL_W-1:0] height_q4,
    output logic                         done,
    output logic [utlm_pkg::VOL_W-1:0]   volume_ml
);

    localparam int AB_W  = 2 * utlm_pkg::DIM_W;
    localparam int X_W   = AB_W + utlm_pkg::LEVEL_W;
    localparam int LO_W  = 16;
    localparam int HI_W  = X_W - LO_W;
    localparam int PLO_W = LO_W + utlm_pkg::PI_W;
    localparam int PHI_W = HI_W + utlm_pkg::PI_W;
    localparam int SUM_W = 64;
    localparam int STG   = 5;

    logic [AB_W-1:0]  ab_reg;
    logic [utlm_pkg::LEVEL_W-1:0] h_reg;
    logic             round_reg;
    logic [X_W-1:0]   x_reg;
    logic [X_W-1:0]   x2_reg;
    logic [PLO_W-1:0] plo_reg;
    logic [PLO_W-1:0] plo2_reg;
    logic [PHI_W-1:0] phi_reg;
    logic [SUM_W-1:0] round_sum;
    logic [X_W:0]     rect_sum;
    logic [utlm_pkg::VOL_W-1:0] vol_reg;
    logic [STG-1:0]   pipe_reg;

    // stage 1: base area product
    always_ff @(posedge aclk) begin
        if (start) begin
            ab_reg    <= AB_W'(dim_a) * AB_W'(dim_b);
            h_reg     <= height_q4;
            round_reg <= round_tank;
        end
    end

    // stages 2 to 4: area times height, then pi in two partial products
    always_ff @(posedge aclk) begin
        x_reg    <= X_W'(ab_reg) * X_W'(h_reg);
        x2_reg   <= x_reg;
        plo_reg  <= PLO_W'(x_reg[LO_W-1:0]) * PLO_W'(utlm_pkg::PI_Q28);
        plo2_reg <= plo_reg;
        phi_reg  <= PHI_W'(x2_reg[X_W-1:LO_W]) * PHI_W'(utlm_pkg::PI_Q28);
    end

    // stage 5: combine and round; both shapes stay below 2^30 at these widths
    always_comb begin
        round_sum = (SUM_W'(phi_reg) << LO_W) + SUM_W'(plo2_reg) + (SUM_W'(1) << 33);
        rect_sum  = (X_W+1)'(x2_reg) + (X_W+1)'(8);
    end

    always_ff @(posedge aclk) begin
        if (pipe_reg[STG-2]) begin
            vol_reg <= round_reg ? utlm_pkg::VOL_W'(round_sum >> 34)
                                 : utlm_pkg::VOL_W'(rect_sum >> 4);
        end
    end

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_reg <= '0;
        end else begin
            pipe_reg <= {pipe_reg[STG-2:0], start};
        end
    end

    assign done      = pipe_reg[STG-1];
    assign volume_ml = vol_reg;

endmodule
